FILE: hw/rtl/swm_pkg.sv
// Shared types, constants and helpers for the sliding window maximum core.
// No dependencies; every module of the core imports this package.
`timescale 1ns / 1ps

package swm_pkg;

  // Deepest window supported (power of two keeps the history ring simple)
  localparam int MAX_WINDOW = 64;
  localparam int DATA_W     = 32;
  localparam int CFG_W      = 7;
  localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W      = $clog2(MAX_WINDOW);

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE = CFG_ADDR_W'(0);

  // Per-transaction control broadcast to every cell
  typedef struct packed {
    logic [DATA_W-1:0] sample;
    logic              clear;
    logic              shift;
    logic              step;
  } swm_ctl_t;

  // History ring status seen by the top level
  typedef struct packed {
    logic [WIN_W-1:0] fill;
    logic [WIN_W-1:0] fill_nxt;
    logic [PTR_W-1:0] ptr;
  } swm_hist_st_t;

  // Window size as used: zero acts as one, large values saturate
  function automatic logic [WIN_W-1:0] eff_window(input logic [CFG_W-1:0] w);
    int unsigned wi;
    wi = 32'(w);
    if (wi < 1) wi = 1;
    if (wi > MAX_WINDOW) wi = MAX_WINDOW;
    return WIN_W'(wi);
  endfunction

endpackage

FILE: hw/rtl/swm_cell.sv
// One slot of the candidate chain: holds a value and a valid bit.
// Depends on swm_pkg; instantiated in a row by the top level.
`timescale 1ns / 1ps

module swm_cell
  import swm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  swm_ctl_t          ctl,
  input  logic              head,      // tied high on the first cell
  input  logic [DATA_W-1:0] up_val,    // value of the next cell toward the tail
  input  logic              up_ge,     // that cell survives the pop
  input  logic              dn_ge,     // previous cell survives the pop
  output logic [DATA_W-1:0] val_o,
  output logic [DATA_W-1:0] val_nxt_o,
  output logic              valid_o,
  output logic              ge_o
);

  logic [DATA_W-1:0] val_r, val_nxt;
  logic              valid_r, valid_nxt;
  logic [DATA_W-1:0] src_val;
  logic              keep, prev_keep;

  // Survives the pop: valid, no frame clear, and not below the sample
  assign ge_o = valid_r && !ctl.clear && !($signed(val_r) < $signed(ctl.sample));

  // On a shift (head drop or full chain) every cell takes its tail-side neighbor's place
  always_comb begin
    src_val   = ctl.shift ? up_val : val_r;
    keep      = ctl.shift ? up_ge  : ge_o;
    prev_keep = head || (ctl.shift ? ge_o : dn_ge);
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (ctl.step) begin
      if (keep) begin
        val_nxt   = src_val;
        valid_nxt = 1'b1;
      end else if (prev_keep) begin
        // first free slot after the kept prefix takes the new sample
        val_nxt   = ctl.sample;
        valid_nxt = 1'b1;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_o     = val_r;
  assign val_nxt_o = val_nxt;
  assign valid_o   = valid_r;

endmodule

FILE: hw/rtl/swm_hist.sv
// Sample history ring, write pointer and fill counter.
// Depends on swm_pkg; the leaving sample is prefetched into a register.
`timescale 1ns / 1ps

module swm_hist
  import swm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              clear,
  input  logic [DATA_W-1:0] sample,
  input  logic [WIN_W-1:0]  win_next,  // window size in force for the next transaction
  output logic [DATA_W-1:0] leave_o,   // sample leaving the window on the next step
  output swm_hist_st_t      st_o
);

  logic [DATA_W-1:0] mem [MAX_WINDOW];
  logic [DATA_W-1:0] leave_r;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt, wr_addr, rd_addr;
  logic [WIN_W-1:0]  fill_r, fill_nxt, fill_base;
  logic [PTR_W:0]    rd_sum;

  // Pointer and fill update
  always_comb begin
    wr_addr   = clear ? '0 : ptr_r;
    fill_base = clear ? '0 : fill_r;
    ptr_nxt   = ptr_r;
    fill_nxt  = fill_r;
    if (step) begin
      ptr_nxt  = (wr_addr == PTR_W'(MAX_WINDOW - 1)) ? '0 : wr_addr + 1'b1;
      fill_nxt = (fill_base < WIN_W'(MAX_WINDOW)) ? fill_base + 1'b1 : fill_base;
    end
  end

  // Address of the sample that leaves with the next transaction
  always_comb begin
    rd_sum  = (PTR_W + 1)'(ptr_nxt) + (PTR_W + 1)'(MAX_WINDOW)
              - (PTR_W + 1)'(win_next);
    rd_addr = (rd_sum >= (PTR_W + 1)'(MAX_WINDOW))
              ? PTR_W'(rd_sum - (PTR_W + 1)'(MAX_WINDOW)) : PTR_W'(rd_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      fill_r <= '0;
    end else begin
      ptr_r  <= ptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Ring storage; a write to the address being read is forwarded
  always_ff @(posedge clk) begin
    if (step) begin
      mem[wr_addr] <= sample;
    end
    if (step && (wr_addr == rd_addr)) begin
      leave_r <= sample;
    end else begin
      leave_r <= mem[rd_addr];
    end
  end

  assign leave_o       = leave_r;
  assign st_o.fill     = fill_r;
  assign st_o.fill_nxt = fill_nxt;
  assign st_o.ptr      = ptr_r;

endmodule

FILE: hw/rtl/sliding_window_maximum_core.sv
// Sliding window maximum over signed 32-bit samples: top level.
// Depends on swm_pkg, swm_cell and swm_hist.
`timescale 1ns / 1ps

// The core takes one sample per clock unless stalled and returns, in the
// following cycle, the largest of the last window_size samples once that
// many samples have arrived since the last frame_start; earlier samples
// give no result. Candidates sit in a row of 64 cells that compare
// against the new sample in parallel, so popping any number of smaller
// entries, dropping the expired head and appending all happen in the same
// cycle. The sample leaving the window is prefetched from the history ring
// into a register, so the ring's single read port never stalls the input.
// The input stalls only while a result waits on out_tready. window_size is
// at byte address 0 and should be written while no samples are in flight.

module sliding_window_maximum_core
  import swm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,   // [31:0] sample
  input  logic [0:0]            in_tuser,   // [0] frame_start
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DATA_W-1:0]     out_tdata,  // [31:0] window_max
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [CFG_W-1:0]  win_size_r, win_size_nxt;
  logic [WIN_W-1:0]  win_eff, win_next;
  logic              cfg_wr;
  logic              step, clear, head_drop;
  swm_ctl_t          ctl;
  swm_hist_st_t      hist_st;
  logic [DATA_W-1:0] leave;
  logic [DATA_W-1:0] cell_val [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] cell_valid, cell_ge;
  logic [DATA_W-1:0] head_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                  && (cfg_paddr[CFG_ADDR_W-1:2] == REG_WINDOW_SIZE[CFG_ADDR_W-1:2]);
  assign win_size_nxt = cfg_wr ? cfg_pwdata[CFG_W-1:0] : win_size_r;
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == REG_WINDOW_SIZE[CFG_ADDR_W-1:2])
                      ? CFG_DATA_W'(win_size_r) : '0;
  assign win_eff  = eff_window(win_size_r);
  assign win_next = eff_window(win_size_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r <= CFG_W'(1);
    end else begin
      win_size_r <= win_size_nxt;
    end
  end

  // Transaction control
  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;
  assign clear     = in_tuser[0];

  // Expired head: the window is full and the head equals the leaving sample
  assign head_drop = !clear && (hist_st.fill >= win_eff) && cell_valid[0]
                     && (cell_val[0] == leave);

  always_comb begin
    ctl.sample = in_tdata;
    ctl.clear  = clear;
    // a full chain with nothing popped also loses its head
    ctl.shift  = head_drop || cell_ge[MAX_WINDOW-1];
    ctl.step   = step;
  end

  swm_hist u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .clear    (clear),
    .sample   (in_tdata),
    .win_next (win_next),
    .leave_o  (leave),
    .st_o     (hist_st)
  );

  // Candidate chain, head at cell 0
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic [DATA_W-1:0] up_val;
    logic              up_ge, dn_ge;
    if (i == MAX_WINDOW - 1) begin : g_tail
      assign up_val = '0;
      assign up_ge  = 1'b0;
    end else begin : g_mid
      assign up_val = cell_val[i+1];
      assign up_ge  = cell_ge[i+1];
    end
    if (i == 0) begin : g_head
      assign dn_ge = 1'b1;
      swm_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .head      (1'b1),
        .up_val    (up_val),
        .up_ge     (up_ge),
        .dn_ge     (dn_ge),
        .val_o     (cell_val[i]),
        .val_nxt_o (head_nxt),
        .valid_o   (cell_valid[i]),
        .ge_o      (cell_ge[i])
      );
    end else begin : g_body
      assign dn_ge = cell_ge[i-1];
      swm_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .head      (1'b0),
        .up_val    (up_val),
        .up_ge     (up_ge),
        .dn_ge     (dn_ge),
        .val_o     (cell_val[i]),
        .val_nxt_o (),
        .valid_o   (cell_valid[i]),
        .ge_o      (cell_ge[i])
      );
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = (hist_st.fill_nxt >= win_eff);
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= head_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Occupied cells always form a prefix of the chain
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_valid & MAX_WINDOW'(cell_valid + 1'b1)) == '0)
    else $error("candidate chain has a gap");

  // Every accepted sample leaves at least one candidate
  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> cell_valid[0])
    else $error("candidate chain empty after a sample");

  // Until saturation the write pointer tracks the fill count
  a_ptr_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (hist_st.fill < WIN_W'(MAX_WINDOW)) |-> (hist_st.ptr == hist_st.fill[PTR_W-1:0]))
    else $error("history pointer out of step with fill count");

  // A full window yields a result on the next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (hist_st.fill_nxt >= win_eff)) |=> out_valid_r)
    else $error("missing result for a full window");

endmodule
